/* rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Shared widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CW                = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam int ATAN_COUNT        = 31;

  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

/* rtl/e2q_cordic.sv */
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// One rotation stage per register stage, turns an angle into cos and sin of its half.
// ----------------------------------------------------------------------------
module e2q_cordic import e2q_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output logic signed [CW-1:0]         cos_o,
  output logic signed [CW-1:0]         sin_o
);
  logic signed [CW-1:0] x_q [1:CORDIC_STAGES];
  logic signed [CW-1:0] y_q [1:CORDIC_STAGES];
  logic signed [CW-1:0] z_q [1:CORDIC_STAGES-1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] x_s, y_s, z_s;
    logic signed [CW-1:0] x_d, y_d;

    if (i == 0) begin : g_first
      assign x_s = GAIN_Q30;
      assign y_s = '0;
      assign z_s = CW'(angle_i) <<< (31 - ANGLE_BITS);
    end else begin : g_next
      assign x_s = x_q[i];
      assign y_s = y_q[i];
      assign z_s = z_q[i];
    end

    always_comb begin
      if (z_s >= 0) begin
        x_d = x_s - (y_s >>> i);
        y_d = y_s + (x_s >>> i);
      end else begin
        x_d = x_s + (y_s >>> i);
        y_d = y_s - (x_s >>> i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_angle
      logic signed [CW-1:0] z_d;
      assign z_d = (z_s >= 0) ? z_s - atan_lut(5'(i)) : z_s + atan_lut(5'(i));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i+1] <= z_d;
        end
      end
    end
  end

  assign cos_o = x_q[CORDIC_STAGES];
  assign sin_o = y_q[CORDIC_STAGES];
endmodule

/* rtl/e2q_combine.sv */
// ----------------------------------------------------------------------------
// Product combiner
// Pair products, triple products, rounding and saturation in registered stages.
// ----------------------------------------------------------------------------
module e2q_combine import e2q_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [CW-1:0]        cy_i, sy_i, cp_i, sp_i, cr_i, sr_i,
  output logic signed [FRAC_BITS+1:0] w_o, x_o, y_o, z_o
);
  localparam int PW = 2 * CW;
  localparam int OW = FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF30 = PW'(1) <<< 29;
  localparam logic signed [PW-1:0] HALFF  = PW'(1) <<< (59 - FRAC_BITS);
  localparam logic signed [PW-1:0] LIM    = PW'(1) <<< FRAC_BITS;

  logic signed [PW-1:0] cpcy_q, spsy_q, spcy_q, cpsy_q;
  logic signed [CW-1:0] cr_q, sr_q, cr2_q, sr2_q;
  logic signed [CW-1:0] a_q, b_q, c_q, d_q;
  logic signed [PW-1:0] t_q [8];
  logic signed [OW-1:0] w_q, x_q, y_q, z_q;

  function automatic logic signed [OW-1:0] fin(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + HALFF) >>> (60 - FRAC_BITS);
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return OW'(r);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cpcy_q <= PW'(cp_i) * PW'(cy_i);
      spsy_q <= PW'(sp_i) * PW'(sy_i);
      spcy_q <= PW'(sp_i) * PW'(cy_i);
      cpsy_q <= PW'(cp_i) * PW'(sy_i);
      cr_q <= cr_i;
      sr_q <= sr_i;
      a_q <= CW'((cpcy_q + HALF30) >>> 30);
      b_q <= CW'((spsy_q + HALF30) >>> 30);
      c_q <= CW'((spcy_q + HALF30) >>> 30);
      d_q <= CW'((cpsy_q + HALF30) >>> 30);
      cr2_q <= cr_q;
      sr2_q <= sr_q;
      t_q[0] <= PW'(cr2_q) * PW'(a_q);
      t_q[1] <= PW'(sr2_q) * PW'(b_q);
      t_q[2] <= PW'(sr2_q) * PW'(a_q);
      t_q[3] <= PW'(cr2_q) * PW'(b_q);
      t_q[4] <= PW'(cr2_q) * PW'(c_q);
      t_q[5] <= PW'(sr2_q) * PW'(d_q);
      t_q[6] <= PW'(cr2_q) * PW'(d_q);
      t_q[7] <= PW'(sr2_q) * PW'(c_q);
      w_q <= fin(t_q[0] + t_q[1]);
      x_q <= fin(t_q[2] - t_q[3]);
      y_q <= fin(t_q[4] + t_q[5]);
      z_q <= fin(t_q[6] - t_q[7]);
    end
  end

  assign w_o = w_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

/* rtl/euler_to_quaternion.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion
// Z-Y-X Euler angles to a unit quaternion in signed Q2.FRAC_BITS.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata fields (lowest bit up)
// s_axis   in         yaw_angle, pitch_angle, roll_angle
// m_axis   out        quat_w, quat_x, quat_y, quat_z
//
// One item is taken per cycle while the output is not stalled; the pipeline is
// made of the CORDIC stages and the four product and rounding stages.
// Reset clears only the valid bits of the pipeline.
// A stall at the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module euler_to_quaternion import e2q_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // yaw_angle, pitch_angle, roll_angle
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  localparam int LAT = CORDIC_STAGES + 4;
  localparam int OW  = FRAC_BITS + 2;
  localparam int DW  = ((4*OW+7)/8)*8;

  logic [LAT-1:0] vld_q;
  logic en;
  logic signed [CW-1:0] cy, sy, cp, sp, cr, sr;
  logic signed [OW-1:0] w, x, y, z;

  assign en = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[ANGLE_BITS-1:0]), .cos_o(cy), .sin_o(sy)
  );
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .cos_o(cp), .sin_o(sp)
  );
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
    .cos_o(cr), .sin_o(sr)
  );

  e2q_combine #(.FRAC_BITS(FRAC_BITS)) u_comb (
    .clk_i, .en_i(en), .cy_i(cy), .sy_i(sy), .cp_i(cp), .sp_i(sp), .cr_i(cr),
    .sr_i(sr), .w_o(w), .x_o(x), .y_o(y), .z_o(z)
  );

  assign m_axis_tdata = DW'({z, y, x, w});
endmodule

/* rtl/e2q_checker.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion checker
// Port-level properties of the stream pipeline.
// ----------------------------------------------------------------------------
module e2q_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled while output empty");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accepted in stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed in stall");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion testbench
// Drives yaw, pitch and roll items into the block under varied source and
// sink idling, predicts each quaternion with a CORDIC model in fixed point
// and compares every result field by field in order.
// ----------------------------------------------------------------------------
class quat_scoreboard;
  logic [71:0] pending_quats[$];
  int          mismatches;

  function void half_cos_sin(logic [15:0] ang, output logic signed [63:0] c,
                             output logic signed [63:0] s);
    logic signed [63:0] z, x, y, dx, dy;
    z = 64'(signed'(ang)) * (64'sd1 <<< 15);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < e2q_pkg::CORDIC_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(e2q_pkg::atan_lut(5'(i)));
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(e2q_pkg::atan_lut(5'(i)));
      end
    end
    c = x;
    s = y;
  endfunction

  function logic signed [63:0] prod_q30(logic signed [63:0] a,
                                        logic signed [63:0] b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function logic [17:0] round_part(logic signed [63:0] q60);
    logic signed [63:0] v;
    v = (q60 + (64'sd1 <<< 43)) >>> 44;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v[17:0];
  endfunction

  function void note_angles(logic [47:0] angles);
    logic signed [63:0] cy, sy, cp, sp, cr, sr, cpcy, spsy, spcy, cpsy;
    half_cos_sin(angles[15:0], cy, sy);
    half_cos_sin(angles[31:16], cp, sp);
    half_cos_sin(angles[47:32], cr, sr);
    cpcy = prod_q30(cp, cy);
    spsy = prod_q30(sp, sy);
    spcy = prod_q30(sp, cy);
    cpsy = prod_q30(cp, sy);
    pending_quats.insert(pending_quats.size(),
                         {round_part(cr * cpsy - sr * spcy),
                          round_part(cr * spcy + sr * cpsy),
                          round_part(sr * cpcy - cr * spsy),
                          round_part(cr * cpcy + sr * spsy)});
  endfunction

  function void check_quat(logic [71:0] got);
    logic [71:0] want;
    if (pending_quats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected quaternion %h", got);
      return;
    end
    want = pending_quats.pop_front();
    for (int f = 0; f < 4; f++) begin
      if (got[f*18 +: 18] !== want[f*18 +: 18]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Part %0d mismatch: expected %h, got %h", f, want[f*18 +: 18],
                   got[f*18 +: 18]);
      end
    end
  endfunction
endclass

module tb_top;
  import e2q_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  quat_scoreboard board = new();
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_sink = 1'b0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  euler_to_quaternion dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) board.note_angles(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) board.check_quat(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && board.pending_quats.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !hold_sink && ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {roll, pitch, yaw};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [15:0] a[3];
    for (int n = 0; n < count; n++) begin
      foreach (a[k]) begin
        case ($urandom_range(3))
          0: a[k] = 16'($urandom_range(8)) - 16'd4;
          1: a[k] = 16'h8000 + 16'($urandom_range(8)) - 16'd4;
          default: a[k] = 16'($urandom());
        endcase
      end
      send_angles(a[0], a[1], a[2]);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_quats.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] corners[8] = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000,
                                16'hc000, 16'h0001, 16'hffff, 16'h2000};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (corners[k]) send_angles(corners[k], corners[7-k], corners[(k+3)%8]);
    for (int k = 0; k < 3; k++) begin
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    end
    send_angles(16'h5555, 16'haaaa, 16'h5555);
    send_angles(16'haaaa, 16'h5555, 16'haaaa);
    send_random(250);
    send_idle_pct = 76; send_random(250);
    send_idle_pct = 0;  sink_stall_pct = 76; send_random(250);
    drain();
    fork
      begin
        hold_sink = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      send_random(60);
    join
    send_idle_pct = 28; sink_stall_pct = 28; send_random(250);
    send_idle_pct = 0;  sink_stall_pct = 0;  send_random(175);
    drain();
    repeat (CORDIC_STAGES_DEF + 20) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending_quats.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
